FILE: rtl/lsac_pkg.sv
// Package with shared types, constants and codes of the load-shaping actuator controller.
package lsac_pkg;

  localparam int unsigned Axes       = 3;
  localparam int unsigned SampleBits = 12;
  localparam int unsigned AxisW      = $clog2(Axes);
  localparam int unsigned SumW       = SampleBits + $clog2(Axes + 1);
  localparam int unsigned FracW      = 17;
  localparam int unsigned StepW      = 15;
  localparam int unsigned PctW       = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  // Divider: dividend up to 32 bits, divisor up to SumW bits.
  localparam int unsigned DivNW      = 32;
  localparam int unsigned DivDW      = (SumW > 12) ? SumW : 12;
  localparam int unsigned DivCntW    = $clog2(DivNW + 1);

  localparam logic [CfgIdxW-1:0] RegMaxSteps = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNoise    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScale0   = 3'd3;

  typedef enum logic [2:0] {
    ModeDiscon    = 3'd0,
    ModeIdle      = 3'd1,
    ModeMeasuring = 3'd2,
    ModeMeasured  = 3'd3,
    ModeActuating = 3'd4,
    ModeDone      = 3'd5,
    ModeHoming    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    CmdNone   = 2'd0,
    CmdButton = 2'd1,
    CmdHome   = 2'd2,
    CmdStop   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                   connector_present;
    logic                   button_edge;
    logic [1:0]             cmd;
    logic [SampleBits-1:0]  sample_a;
    logic [SampleBits-1:0]  sample_b;
    logic [SampleBits-1:0]  sample_c;
    logic [SampleBits-1:0]  sample_aux;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic             snapshot_flag;
    logic             drivers_cut;
    logic [PctW-1:0]  load_pct_a;
    logic [PctW-1:0]  load_pct_b;
    logic [PctW-1:0]  load_pct_c;
    logic [PctW-1:0]  live_pct_a;
    logic [PctW-1:0]  live_pct_b;
    logic [PctW-1:0]  live_pct_c;
    logic [StepW-1:0] position_a;
    logic [StepW-1:0] position_b;
    logic [StepW-1:0] position_c;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;     // latch the input item
    logic             meas_start;  // start fraction division of axis
    logic             live_start;  // start live division of axis
    logic             live_write;  // write live percent of axis (after division, floor or zero scale)
    logic             live_zero;   // live reading is zero (under floor)
    logic             live_full;   // live reading is 100 (zero scale)
    logic             meas_write;  // write fraction/target of axis
    logic             act_copy;    // copy targets to positions
    logic             home_zero;   // zero positions
    logic [AxisW-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic            div_done;
    logic            any_pos;
    logic [Axes-1:0] under_floor;
    logic [Axes-1:0] scale_zero;
  } dp_sts_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMeas = 6'b000010,
    StMeasW= 6'b000100,
    StLive = 6'b001000,
    StLiveW= 6'b010000,
    StOut  = 6'b100000
  } state_e;

endpackage

FILE: rtl/lsac_stream_if.sv
// Valid/ready stream interface carrying one payload of type payload_t.
interface lsac_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/lsac_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module lsac_divider import lsac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quot_o
);
  logic [DivNW-1:0] quot_q, quot_d;
  logic [DivDW:0]   rem_q, rem_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DivDW:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DivDW-1:0], quot_q[DivNW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DivCntW'(DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

FILE: rtl/lsac_datapath.sv
// Datapath: input latch, mode register, per-axis state, shared divider and result.
module lsac_datapath import lsac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            item_i,
  input  dp_cmd_t             cmd_i,
  input  mode_e               mode_i,
  input  logic                mode_we_i,
  input  logic                cut_i,
  output dp_sts_t             sts_o,
  output in_item_t            item_o,
  output out_item_t           result_o
);
  logic [StepW-1:0]      max_steps_q;
  logic [15:0]           deadband_q;
  logic [SampleBits-1:0] noise_q;
  logic [11:0]           scale_q [Axes];

  in_item_t         item_q;
  logic [2:0]       mode_q;
  logic             cut_q;
  logic [StepW-1:0] pos_q [Axes];
  logic [StepW-1:0] tgt_q [Axes];
  logic [FracW-1:0] frac_q [Axes];
  logic [PctW-1:0]  live_q [Axes];
  logic [PctW-1:0]  lpct_q [Axes];

  logic [SampleBits-1:0] smp [Axes];
  logic [SumW-1:0]  sum, sum_f;
  logic             div_start;
  logic             div_done;
  logic [DivNW-1:0] div_num, quot;
  logic [DivDW-1:0] div_den;

  // Combinational measurement arithmetic: fraction, extension, target product, live and load percent.
  logic [FracW-1:0] frac_c;
  logic [16:0]      ext;
  logic [31:0]      prod;
  logic [PctW-1:0]  live_c;
  logic [23:0]      lp_prod;

  assign smp[0] = item_q.sample_a;
  assign smp[1] = item_q.sample_b;
  assign smp[2] = item_q.sample_c;

  assign sum   = SumW'(item_q.sample_a) + SumW'(item_q.sample_b) +
                 SumW'(item_q.sample_c) + SumW'(item_q.sample_aux);
  assign sum_f = (sum == '0) ? SumW'(1) : sum;

  always_comb begin
    div_start = cmd_i.meas_start | cmd_i.live_start;
    if (cmd_i.meas_start) begin
      div_num = DivNW'({smp[cmd_i.axis], 16'd0});
      div_den = DivDW'(sum_f);
    end else begin
      div_num = DivNW'(smp[cmd_i.axis]) * DivNW'(100);
      div_den = DivDW'(scale_q[cmd_i.axis]);
    end
  end

  lsac_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    frac_c = (quot > DivNW'(32'h10000)) ? FracW'(17'h10000) : FracW'(quot);
    ext    = 17'h10000 - frac_c;
    if (ext < {1'b0, deadband_q}) ext = '0;
    prod   = 32'(ext) * 32'(max_steps_q);
    live_c = (quot > DivNW'(100)) ? PctW'(100) : PctW'(quot);
    lp_prod = 24'(frac_c) * 24'd100;
  end

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.any_pos  = 1'b0;
    for (int i = 0; i < Axes; i++) begin
      if (pos_q[i] != '0) sts_o.any_pos = 1'b1;
      sts_o.under_floor[i] = smp[i] < noise_q;
      sts_o.scale_zero[i]  = scale_q[i] == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steps_q <= StepW'(21000);
      deadband_q  <= 16'd5243;
      noise_q     <= SampleBits'(150);
      for (int i = 0; i < Axes; i++) scale_q[i] <= 12'd3;
      mode_q <= ModeDiscon;
      cut_q  <= 1'b0;
      for (int i = 0; i < Axes; i++) begin
        pos_q[i]  <= '0;
        tgt_q[i]  <= '0;
        frac_q[i] <= '0;
        live_q[i] <= '0;
        lpct_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMaxSteps: max_steps_q <= cfg_data_i[StepW-1:0];
          RegDeadband: deadband_q  <= cfg_data_i;
          RegNoise:    noise_q     <= cfg_data_i[SampleBits-1:0];
          default: begin
            for (int i = 0; i < Axes; i++)
              if (cfg_idx_i == RegScale0 + CfgIdxW'(i)) scale_q[i] <= cfg_data_i[11:0];
          end
        endcase
      end
      if (mode_we_i) begin
        mode_q <= mode_i;
        cut_q  <= cut_i;
      end
      if (cmd_i.meas_write) begin
        frac_q[cmd_i.axis] <= frac_c;
        tgt_q[cmd_i.axis]  <= prod[16 +: StepW];
        lpct_q[cmd_i.axis] <= PctW'(lp_prod[23:16]);
      end
      if (cmd_i.live_write) begin
        if (cmd_i.live_zero)      live_q[cmd_i.axis] <= '0;
        else if (cmd_i.live_full) live_q[cmd_i.axis] <= PctW'(100);
        else                      live_q[cmd_i.axis] <= live_c;
      end
      if (cmd_i.act_copy)  for (int i = 0; i < Axes; i++) pos_q[i] <= tgt_q[i];
      if (cmd_i.home_zero) for (int i = 0; i < Axes; i++) pos_q[i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  assign item_o = item_q;

  logic snap;
  assign snap = (mode_q == ModeActuating) || (mode_q == ModeDone);
  always_comb begin
    result_o.mode          = mode_q;
    result_o.snapshot_flag = snap;
    result_o.drivers_cut   = cut_q;
    result_o.load_pct_a    = lpct_q[0];
    result_o.load_pct_b    = lpct_q[1];
    result_o.load_pct_c    = lpct_q[2];
    result_o.live_pct_a    = live_q[0];
    result_o.live_pct_b    = live_q[1];
    result_o.live_pct_c    = live_q[2];
    result_o.position_a    = snap ? pos_q[0] : '0;
    result_o.position_b    = snap ? pos_q[1] : '0;
    result_o.position_c    = snap ? pos_q[2] : '0;
  end
endmodule

FILE: rtl/lsac_controller.sv
// Controller: mode decision and sequencing of the shared divider per pass.
module lsac_controller import lsac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  in_item_t  item_i,
  input  logic [2:0] mode_cur_i,
  input  dp_sts_t   sts_i,
  output dp_cmd_t   cmd_o,
  output mode_e     mode_o,
  output logic      mode_we_o,
  output logic      cut_o
);
  state_e st_q, st_d;
  logic [AxisW-1:0] ax_q, ax_d;
  logic live_run_q, live_run_d;
  logic ov_q, ov_d;

  // Mode decision for the latched request.
  mode_e m_pre, m_new;
  logic  cut, btn;
  always_comb begin
    m_pre = mode_e'(mode_cur_i);
    cut   = item_i.cmd == CmdStop;
    btn   = item_i.button_edge | (item_i.cmd == CmdButton);
    if (item_i.cmd == CmdHome && m_pre != ModeHoming && m_pre != ModeActuating)
      m_pre = ModeHoming;
    if (!item_i.connector_present && m_pre != ModeDiscon) begin
      cut   = 1'b1;
      m_pre = ModeDiscon;
    end
    if (item_i.connector_present && m_pre == ModeDiscon)
      m_pre = sts_i.any_pos ? ModeHoming : ModeIdle;
    m_new = m_pre;
    case (m_pre)
      ModeIdle:      if (btn) m_new = ModeMeasuring;
      ModeMeasuring: m_new = ModeMeasured;
      ModeMeasured:  if (btn) m_new = ModeActuating;
      ModeActuating: m_new = ModeDone;
      ModeHoming:    m_new = ModeIdle;
      default:       m_new = m_pre;
    endcase
  end

  logic is_meas, live_en;
  assign is_meas = m_pre == ModeMeasuring;
  assign live_en = m_new != ModeActuating && m_new != ModeHoming;

  always_comb begin
    st_d = st_q;
    ax_d = ax_q;
    live_run_d = live_run_q;
    ov_d = ov_q;
    cmd_o = '0;
    cmd_o.axis = ax_q;
    mode_o = m_new;
    mode_we_o = 1'b0;
    cut_o = cut;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i && !ov_q) begin
          cmd_o.capture = 1'b1;
          ax_d = '0;
          st_d = StMeas;
        end
      end
      StMeas: begin
        // Decision step: either measure axis, or go to the live phase.
        if (is_meas) begin
          cmd_o.meas_start = 1'b1;
          st_d = StMeasW;
        end else begin
          st_d = StLive;
        end
      end
      StMeasW: begin
        if (sts_i.div_done) begin
          cmd_o.meas_write = 1'b1;
          if (ax_q == AxisW'(Axes - 1)) begin
            ax_d = '0;
            st_d = StLive;
          end else begin
            ax_d = ax_q + 1'b1;
            st_d = StMeas;
          end
        end
      end
      StLive: begin
        if (!live_en) begin
          st_d = StOut;
        end else if (sts_i.under_floor[ax_q] || sts_i.scale_zero[ax_q]) begin
          cmd_o.live_write = 1'b1;
          cmd_o.live_zero = sts_i.under_floor[ax_q];
          cmd_o.live_full = 1'b1;
          if (ax_q == AxisW'(Axes - 1)) st_d = StOut;
          else ax_d = ax_q + 1'b1;
        end else begin
          cmd_o.live_start = 1'b1;
          live_run_d = 1'b1;
          st_d = StLiveW;
        end
      end
      StLiveW: begin
        if (sts_i.div_done) begin
          cmd_o.live_write = 1'b1;
          live_run_d = 1'b0;
          if (ax_q == AxisW'(Axes - 1)) st_d = StOut;
          else begin
            ax_d = ax_q + 1'b1;
            st_d = StLive;
          end
        end
      end
      StOut: begin
        mode_we_o = 1'b1;
        cmd_o.act_copy  = m_pre == ModeActuating;
        cmd_o.home_zero = m_pre == ModeHoming;
        ov_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ax_q <= '0;
      live_run_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d;
      live_run_q <= live_run_d;
      ov_q <= ov_d;
    end
  end

  assign in_ready_o  = (st_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q && !live_run_q;
endmodule

FILE: rtl/load_shaping_actuator_controller_top.sv
// Top level of the load-shaping actuator controller.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------
//   in_if    | in  | valid/ready        | connector, button, cmd, four samples
//   out_if   | out | valid/ready        | mode, flags, percentages, positions
//   cfg      | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A request is captured in the idle state, then runs the measure step, where a
// measuring pass divides the load fraction of each axis, and the live step,
// skipped when the new mode is actuating or homing, where each live reading is
// settled by the noise floor or a zero scale or divided; the result is then
// written and offered. Every division runs on the single shared radix-2
// divider, which gives one quotient bit per cycle and serves the three load
// fractions and the three live percentages.
// Reset is asynchronous and active low and restores every register but the latched request and divider data.
// A new request is taken only after the previous result has been delivered.
module load_shaping_actuator_controller_top import lsac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lsac_stream_if.sink         in_if,
  lsac_stream_if.source       out_if
);
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  in_item_t item_l;
  out_item_t result;
  mode_e    mode_new;
  logic     mode_we, cut;

  // The controller decides on the latched request held in the datapath.
  lsac_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .item_i(item_l), .mode_cur_i(result.mode),
    .sts_i(sts), .cmd_o(cmd),
    .mode_o(mode_new), .mode_we_o(mode_we), .cut_o(cut)
  );

  lsac_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(in_if.payload), .cmd_i(cmd),
    .mode_i(mode_new), .mode_we_i(mode_we), .cut_i(cut),
    .sts_o(sts), .item_o(item_l), .result_o(result)
  );

  assign out_if.payload = result;
endmodule

FILE: tb/sv/tb_load_shaping_actuator_controller_top.sv
// Self-checking testbench for the load-shaping actuator controller top level.
`timescale 1ns / 1ps

module tb_load_shaping_actuator_controller_top;
  import lsac_pkg::*;

  // Scoreboard: keeps its own copy of the controller state and configuration,
  // predicts one result per accepted poll request and checks each result in order.
  class poll_scoreboard;
    logic [14:0] max_steps;
    logic [15:0] deadband;
    logic [11:0] noise;
    logic [11:0] scale [3];
    mode_e       mode;
    logic [14:0] pos [3];
    logic [14:0] tgt [3];
    logic [16:0] frac [3];
    logic [6:0]  live [3];
    out_item_t   pending [$];
    int          mismatches;
    int          checked;
    int          measures;
    int          actuations;
    int          homings;

    function new();
      max_steps = 15'd21000;
      deadband  = 16'd5243;
      noise     = 12'd150;
      mode      = ModeDiscon;
      for (int i = 0; i < 3; i++) begin
        scale[i] = 12'd3;
        pos[i]   = '0;
        tgt[i]   = '0;
        frac[i]  = '0;
        live[i]  = '0;
      end
      mismatches = 0;
      checked    = 0;
      measures   = 0;
      actuations = 0;
      homings    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegMaxSteps) max_steps = data[14:0];
      else if (idx == RegDeadband) deadband = data;
      else if (idx == RegNoise) noise = data[11:0];
      else if (idx >= RegScale0 && idx < RegScale0 + 3) scale[idx - RegScale0] = data[11:0];
    endfunction

    function void note_request(in_item_t it);
      logic [11:0] s [3];
      logic        btn, cut, snap, any;
      longint      sum, f, ext, p;
      out_item_t   r;
      s[0] = it.sample_a;
      s[1] = it.sample_b;
      s[2] = it.sample_c;
      btn  = it.button_edge;
      cut  = 1'b0;
      if (it.cmd == CmdStop) cut = 1'b1;
      if (it.cmd == CmdHome && mode != ModeHoming && mode != ModeActuating) mode = ModeHoming;
      if (it.cmd == CmdButton) btn = 1'b1;
      if (!it.connector_present && mode != ModeDiscon) begin
        cut  = 1'b1;
        mode = ModeDiscon;
      end
      if (it.connector_present && mode == ModeDiscon) begin
        any  = (pos[0] != 0) || (pos[1] != 0) || (pos[2] != 0);
        mode = any ? ModeHoming : ModeIdle;
      end
      case (mode)
        ModeIdle: if (btn) mode = ModeMeasuring;
        ModeMeasuring: begin
          sum = it.sample_aux + s[0] + s[1] + s[2];
          if (sum < 1) sum = 1;
          for (int i = 0; i < 3; i++) begin
            f = (longint'(s[i]) << 16) / sum;
            if (f > 65536) f = 65536;
            frac[i] = f[16:0];
            ext = 65536 - f;
            if (ext < deadband) ext = 0;
            ext = (ext * max_steps) >> 16;
            tgt[i] = ext[14:0];
          end
          measures++;
          mode = ModeMeasured;
        end
        ModeMeasured: if (btn) mode = ModeActuating;
        ModeActuating: begin
          for (int i = 0; i < 3; i++) pos[i] = tgt[i];
          actuations++;
          mode = ModeDone;
        end
        ModeHoming: begin
          for (int i = 0; i < 3; i++) pos[i] = '0;
          homings++;
          mode = ModeIdle;
        end
        default: ;
      endcase
      if (mode != ModeActuating && mode != ModeHoming) begin
        for (int i = 0; i < 3; i++) begin
          if (s[i] < noise) live[i] = '0;
          else if (scale[i] == 0) live[i] = 7'd100;
          else begin
            p = (longint'(s[i]) * 100) / scale[i];
            live[i] = (p > 100) ? 7'd100 : p[6:0];
          end
        end
      end
      snap            = (mode == ModeActuating || mode == ModeDone);
      r.mode          = mode;
      r.snapshot_flag = snap;
      r.drivers_cut   = cut;
      r.load_pct_a    = pct_of(frac[0]);
      r.load_pct_b    = pct_of(frac[1]);
      r.load_pct_c    = pct_of(frac[2]);
      r.live_pct_a    = live[0];
      r.live_pct_b    = live[1];
      r.live_pct_c    = live[2];
      r.position_a    = snap ? pos[0] : '0;
      r.position_b    = snap ? pos[1] : '0;
      r.position_c    = snap ? pos[2] : '0;
      pending.push_back(r);
    endfunction

    function logic [6:0] pct_of(logic [16:0] q);
      longint v;
      v = (longint'(q) * 100) >> 16;
      if (v > 100) v = 100;
      return v[6:0];
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: mode %0d/%0d snap %0b/%0b cut %0b/%0b",
                   checked, want.mode, got.mode, want.snapshot_flag, got.snapshot_flag,
                   want.drivers_cut, got.drivers_cut);
          $display("  load %0d %0d %0d / %0d %0d %0d  live %0d %0d %0d / %0d %0d %0d",
                   want.load_pct_a, want.load_pct_b, want.load_pct_c,
                   got.load_pct_a, got.load_pct_b, got.load_pct_c,
                   want.live_pct_a, want.live_pct_b, want.live_pct_c,
                   got.live_pct_a, got.live_pct_b, got.live_pct_c);
          $display("  pos %0d %0d %0d / %0d %0d %0d",
                   want.position_a, want.position_b, want.position_c,
                   got.position_a, got.position_b, got.position_c);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  lsac_stream_if #(.payload_t(in_item_t))  poll_if ();
  lsac_stream_if #(.payload_t(out_item_t)) status_if ();

  load_shaping_actuator_controller_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (poll_if),
    .out_if     (status_if)
  );

  poll_scoreboard board;
  int             sent;
  bit             stimulus_done;
  // While this is set the status receiver holds ready low for a long stretch.
  bit             hold_off;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A third of the gaps are zero and most others short; roughly one in eighteen is long.
  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // Drives one register write, mirrored into the scoreboard at the same edge.
  // The enable then drops before the task returns.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one poll request and waits until the controller takes it.
  // Valid stays high after acceptance until a gap or a drain drops it.
  task automatic send_poll(in_item_t it, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      poll_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    poll_if.valid   <= 1'b1;
    poll_if.payload <= it;
    do @(posedge clk); while (!poll_if.ready);
    board.note_request(it);
    sent++;
  endtask

  function automatic in_item_t make_poll(int c, int b, cmd_e cm, int a, int bb, int cc, int x);
    in_item_t it;
    it.connector_present = c[0];
    it.button_edge       = b[0];
    it.cmd               = cm;
    it.sample_a          = a[11:0];
    it.sample_b          = bb[11:0];
    it.sample_c          = cc[11:0];
    it.sample_aux        = x[11:0];
    return it;
  endfunction

  function automatic in_item_t random_poll();
    in_item_t it;
    it = make_poll(1, 0, CmdNone, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    // Small sample values now and then so that the noise floor and tiny sums are reached.
    if ($urandom_range(0, 5) == 0) it.sample_a = SampleBits'($urandom_range(0, 200));
    if ($urandom_range(0, 5) == 0) it.sample_b = SampleBits'($urandom_range(0, 200));
    if ($urandom_range(0, 5) == 0) it.sample_c = SampleBits'($urandom_range(0, 200));
    if ($urandom_range(0, 5) == 0) it.sample_aux = SampleBits'($urandom_range(0, 50));
    return it;
  endfunction

  // One well-formed cycle: attach, press, measure, press, actuate, settle, then home.
  task automatic run_sequence();
    in_item_t it;
    int       n;
    n = $urandom_range(0, 2);
    for (int k = 0; k < 7 + n; k++) begin
      it = random_poll();
      if (k == 1 || k == 3) begin
        if ($urandom_range(0, 1)) it.button_edge = 1'b1;
        else it.cmd = CmdButton;
      end
      if (k == 6 + n) it.cmd = CmdHome;
      send_poll(it, 1'b1);
    end
  endtask

  // Noise and broken sequences: random connector, button and command bits.
  task automatic run_noise();
    in_item_t it;
    it = random_poll();
    it.connector_present = ($urandom_range(0, 7) != 0);
    it.button_edge       = 1'($urandom_range(0, 1));
    it.cmd               = 2'($urandom_range(0, 3));
    send_poll(it, 1'b1);
  endtask

  // Waits until every expected result has arrived, then a further latency margin.
  task automatic drain();
    poll_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_config(bit extreme);
    write_reg(RegMaxSteps, extreme ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h0000)
                                   : CfgDataW'($urandom_range(0, 32767)));
    write_reg(RegDeadband, extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                   : CfgDataW'($urandom_range(0, 65535)));
    write_reg(RegNoise, extreme ? ($urandom_range(0, 1) ? 16'h0FFF : 16'h0000)
                                : CfgDataW'($urandom_range(0, 400)));
    for (int i = 0; i < 3; i++)
      write_reg(RegScale0 + CfgIdxW'(i),
                extreme ? ($urandom_range(0, 1) ? 16'h0FFF : 16'h0001)
                        : CfgDataW'($urandom_range(0, 4095)));
  endtask

  // Status receiver: random stalls, plus a long hold-off while hold_off is set.
  initial begin
    status_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && status_if.valid && status_if.ready) board.check_result(status_if.payload);
      if (hold_off) status_if.ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) status_if.ready <= 1'b0;
      else if ($urandom_range(0, 40) == 0) status_if.ready <= 1'b0;
      else status_if.ready <= 1'b1;
    end
  end

  // Main stimulus.
  initial begin
    board           = new();
    sent            = 0;
    stimulus_done   = 1'b0;
    hold_off        = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    poll_if.valid   = 1'b0;
    poll_if.payload = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration: attach, measure, actuate, stop,
    // connector loss with positions held, reattach forcing homing, zero load.
    send_poll(make_poll(1, 0, CmdNone, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 1, CmdNone, 4095, 4095, 4095, 4095), 0);
    send_poll(make_poll(1, 0, CmdNone, 4095, 100, 2000, 0), 0);
    send_poll(make_poll(1, 0, CmdButton, 149, 150, 4095, 0), 0);
    send_poll(make_poll(1, 0, CmdHome, 10, 10, 10, 10), 0);
    send_poll(make_poll(1, 0, CmdStop, 500, 0, 0, 0), 0);
    send_poll(make_poll(0, 0, CmdNone, 500, 500, 500, 0), 0);
    send_poll(make_poll(0, 1, CmdStop, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 0, CmdNone, 300, 300, 300, 300), 0);
    send_poll(make_poll(1, 0, CmdButton, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 0, CmdNone, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 1, CmdHome, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 0, CmdHome, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 1, CmdNone, 0, 0, 0, 0), 0);
    send_poll(make_poll(1, 0, CmdNone, 4095, 0, 0, 0), 0);
    send_poll(make_poll(1, 1, CmdNone, 1, 2, 3, 4), 0);
    send_poll(make_poll(1, 0, CmdHome, 1, 2, 3, 4), 0);
    drain();

    // Extreme settings, including zero scales, zero noise floor, zero deadband and the largest step count.
    write_reg(RegNoise, 16'h0000);
    for (int i = 0; i < 3; i++) write_reg(RegScale0 + CfgIdxW'(i), 16'h0000);
    write_reg(RegMaxSteps, 16'h7FFF);
    write_reg(RegDeadband, 16'h0000);
    write_reg(3'd7, 16'h1234);
    run_sequence();
    drain();

    // Pressure: the receiver holds off while the sender keeps offering requests.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 6; k++) run_noise();
    join
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase % 3 == 0);
      for (int k = 0; k < 15; k++) begin
        if ($urandom_range(0, 3) != 0) run_sequence();
        else run_noise();
      end
      drain();
    end
    stimulus_done = 1'b1;
  end

  // End of run: report once stimulus has finished and every result is in.
  initial begin
    wait (stimulus_done);
    $display("Covered %0d poll requests, %0d results checked: %0d measurements,",
             sent, board.checked, board.measures);
    $display("%0d actuations and %0d homing passes over several register settings.",
             board.actuations, board.homings);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a generous fixed limit for the slowest correct run.
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lsac_pkg.sv
rtl/lsac_stream_if.sv
rtl/lsac_divider.sv
rtl/lsac_datapath.sv
rtl/lsac_controller.sv
rtl/load_shaping_actuator_controller_top.sv
tb/sv/tb_load_shaping_actuator_controller_top.sv
